FILE: hdl/gbwd_pkg.sv
// gbwd_pkg: shared types and constants for the GPU bound window detector.
// Used by every module of the block; depends on nothing.
package gbwd_pkg;

  typedef struct packed {
    logic [6:0]  load_percent;
    logic [11:0] freq_mhz;
    logic        measure_enable;
    logic [31:0] power_sample;
    logic [39:0] elapsed_ns;
    logic        sample_error;
  } in_t;

  typedef struct packed {
    logic        gpu_bound;
    logic        release_sampling;
    logic [31:0] power_measure;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_TQ,
    ST_DIV_P,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic take_tq;
    logic take_pm;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic measure_tick;
    logic div_done;
    logic tq_zero;
  } status_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_LEVEL      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DETECTION_ENABLE = 1'd1;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [6:0]  LOAD_BUSY_MIN   = 7'd45;
  localparam logic [3:0]  IDLE_LIMIT      = 4'd10;
  localparam logic [3:0]  IDLE_MAX        = 4'd15;
  localparam logic [31:0] THRESHOLD_RESET = 32'd300;
  localparam logic [9:0]  POWER_SCALE     = 10'd1000;
  localparam logic [31:0] TIME_SCALE      = 32'd4000;
  localparam int unsigned TIME_SHIFT      = 8;

  // sum / 4000 = ((sum >> 5) * ceil(2^34 / 125)) >> 34, exact for 27-bit operands
  localparam int unsigned TQ_PRE_SHIFT  = 5;
  localparam int unsigned TQ_POST_SHIFT = 34;
  localparam int unsigned TQ_W          = 21;
  localparam logic [27:0] TQ_RECIP      = 28'd137438954;

endpackage

FILE: hdl/gpu_bound_window_detector.sv
// gpu_bound_window_detector: top level, joins the controller and the datapath.
// Depends on gbwd_pkg, gbwd_ctrl, gbwd_dp.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | in_valid / in_ready       | in_data  (gbwd_pkg::in_t)
//   output   | out_valid / out_ready     | out_data (gbwd_pkg::out_t)
//   config   | cfg_we                    | cfg_index, cfg_wdata
//
// One tick at a time. A tick without a measurement goes through EVAL to RESULT;
// a measuring tick with a zero time quotient through EVAL, MUL and TQ; any other
// measuring tick waits in DIV_P for the divider (scaled power by time sum / 4000).
// Reset clears the window, sums, idle count and config to their defaults.
// The finished result sits in the output register; the next transfer is taken
// while it waits, and the sequencer stalls only when a second result is ready.
module gpu_bound_window_detector #(
  parameter int unsigned WINDOW_SAMPLES = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gbwd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gbwd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [gbwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata
);

  gbwd_pkg::cmd_t    cmd;
  gbwd_pkg::status_t status;

  gbwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gbwd_dp #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: hdl/gbwd_div.sv
// gbwd_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on gbwd_pkg for the operand width.
module gbwd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gbwd_pkg::DIV_W-1:0]   dividend,
  input  logic [gbwd_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [gbwd_pkg::DIV_W-1:0]   quotient
);

  logic [gbwd_pkg::DIV_W-1:0]     rem;
  logic [gbwd_pkg::DIV_W-1:0]     rem_next;
  logic [gbwd_pkg::DIV_W-1:0]     quo;
  logic [gbwd_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [gbwd_pkg::DIV_W:0]       shifted;
  logic [gbwd_pkg::DIV_W:0]       trial;
  logic                           fits;

  always_comb begin
    shifted  = {rem, quo[gbwd_pkg::DIV_W-1]};
    trial    = shifted - {1'b0, divisor};
    fits     = !trial[gbwd_pkg::DIV_W];
    rem_next = fits ? trial[gbwd_pkg::DIV_W-1:0] : shifted[gbwd_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= gbwd_pkg::DIV_CNT_W'(gbwd_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gbwd_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[gbwd_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/gbwd_ctrl.sv
// gbwd_ctrl: sequencer for one tick, plus the output valid flag.
// Depends on gbwd_pkg for state, command and status types.
module gbwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gbwd_pkg::status_t   status,
  output gbwd_pkg::cmd_t      cmd
);

  gbwd_pkg::state_t state;
  gbwd_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbwd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gbwd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = gbwd_pkg::ST_EVAL;
        end
      end
      gbwd_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.measure_tick ? gbwd_pkg::ST_MUL : gbwd_pkg::ST_RESULT;
      end
      gbwd_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = gbwd_pkg::ST_TQ;
      end
      gbwd_pkg::ST_TQ: begin
        cmd.take_tq = 1'b1;
        state_next  = status.tq_zero ? gbwd_pkg::ST_RESULT : gbwd_pkg::ST_DIV_P;
      end
      gbwd_pkg::ST_DIV_P: begin
        if (status.div_done) begin
          cmd.take_pm = 1'b1;
          state_next  = gbwd_pkg::ST_RESULT;
        end
      end
      gbwd_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = gbwd_pkg::ST_IDLE;
        end
      end
      default: state_next = gbwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: hdl/gbwd_dp.sv
// gbwd_dp: config registers, idle tracking, sample window with running sums,
// scale multiply, divider and bound compare. Depends on gbwd_pkg, gbwd_div.
module gbwd_dp #(
  parameter int unsigned WINDOW_SAMPLES = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gbwd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_wdata,
  input  gbwd_pkg::in_t                        in_data,
  output gbwd_pkg::out_t                       out_data,
  input  gbwd_pkg::cmd_t                       cmd,
  output gbwd_pkg::status_t                    status
);

  localparam int unsigned SLOT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SAMPLES - 1);

  logic [31:0]       bound_level;
  logic              detection_enable;

  gbwd_pkg::in_t     in_q;
  logic [3:0]        idle_ticks;
  logic [3:0]        idle_inc;
  logic              sampling_attached;
  logic [SLOT_W-1:0] window_slot;
  logic [31:0]       power_window [WINDOW_SAMPLES];
  logic [31:0]       time_window  [WINDOW_SAMPLES];
  logic [31:0]       power_sum;
  logic [31:0]       time_sum;
  logic [31:0]       time_val;
  logic              busy_tick;

  logic [31:0]       power_scaled;
  logic [44:0]       bound_limit;
  logic [54:0]       time_prod;
  logic [gbwd_pkg::TQ_W-1:0] time_quo;
  logic [31:0]       power_measure;
  logic              gpu_bound;
  logic              release_sampling;

  logic              div_start;
  logic [31:0]       div_dividend;
  logic [31:0]       div_divisor;
  logic              div_done;
  logic [31:0]       div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_level      <= gbwd_pkg::THRESHOLD_RESET;
      detection_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbwd_pkg::REG_BOUND_LEVEL:      bound_level      <= cfg_wdata;
        gbwd_pkg::REG_DETECTION_ENABLE: detection_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_tick = in_q.load_percent >= gbwd_pkg::LOAD_BUSY_MIN;
    idle_inc  = (idle_ticks < gbwd_pkg::IDLE_MAX) ? idle_ticks + 4'd1 : idle_ticks;
    time_val  = 32'(in_q.elapsed_ns >> gbwd_pkg::TIME_SHIFT);
    time_prod = {28'd0, time_sum[31:gbwd_pkg::TQ_PRE_SHIFT]} * {27'd0, gbwd_pkg::TQ_RECIP};
  end

  assign status.measure_tick = busy_tick && in_q.measure_enable && !in_q.sample_error;
  assign status.div_done     = div_done;
  assign status.tq_zero      = time_quo == '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks        <= '0;
      sampling_attached <= 1'b0;
      window_slot       <= '0;
      power_sum         <= '0;
      time_sum          <= '0;
      for (int i = 0; i < WINDOW_SAMPLES; i++) begin
        power_window[i] <= '0;
        time_window[i]  <= '0;
      end
    end else if (cmd.eval) begin
      if (!busy_tick) begin
        idle_ticks <= idle_inc;
        if (idle_inc > gbwd_pkg::IDLE_LIMIT && sampling_attached) begin
          sampling_attached <= 1'b0;
        end
      end else begin
        idle_ticks <= '0;
        if (status.measure_tick) begin
          sampling_attached         <= 1'b1;
          power_window[window_slot] <= in_q.power_sample;
          time_window[window_slot]  <= time_val;
          power_sum   <= power_sum - power_window[window_slot] + in_q.power_sample;
          time_sum    <= time_sum - time_window[window_slot] + time_val;
          window_slot <= (window_slot == SLOT_LAST) ? '0 : window_slot + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      release_sampling <= !busy_tick && idle_inc > gbwd_pkg::IDLE_LIMIT && sampling_attached;
      power_measure    <= '0;
      gpu_bound        <= 1'b0;
    end else if (cmd.take_pm) begin
      power_measure <= div_quo;
      gpu_bound     <= detection_enable && in_q.freq_mhz != '0 &&
                       {13'd0, div_quo} >= bound_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      power_scaled <= 32'(power_sum * gbwd_pkg::POWER_SCALE);
      bound_limit  <= ({13'd0, bound_level} + 45'd1) * {33'd0, in_q.freq_mhz};
      time_quo     <= time_prod[gbwd_pkg::TQ_POST_SHIFT +: gbwd_pkg::TQ_W];
    end
  end

  always_comb begin
    div_start    = cmd.take_tq && !status.tq_zero;
    div_dividend = power_scaled;
    div_divisor  = {11'd0, time_quo};
  end

  gbwd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.gpu_bound        <= gpu_bound;
      out_data.release_sampling <= release_sampling;
      out_data.power_measure    <= power_measure;
    end
  end

endmodule
